// ===== rtl/core/chroma_intra_predictor_8x8_assert.svh =====
// Assertion macros for the chroma intra predictor.
// Needs nothing else; included at the end of the top level.
`ifndef CHROMA_INTRA_PREDICTOR_8X8_ASSERT_SVH
`define CHROMA_INTRA_PREDICTOR_8X8_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cip check failed: same cycle");

// The consequent must hold in the cycle after the antecedent.
`define CIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cip check failed: next cycle");

`endif

// ===== rtl/core/cip_pkg.sv =====
// Shared types for the chroma intra predictor.
// Used by the front, the queue, the back and the top level; depends on nothing.
package cip_pkg;

    // How the back end builds each row of a block.
    typedef enum logic [1:0] {
        K_QUAD  = 2'd0,
        K_HOR   = 2'd1,
        K_VER   = 2'd2,
        K_PLANE = 2'd3
    } t_kind;

    localparam int unsigned BASE_W = 17;
    localparam int unsigned GRAD_W = 12;

    // One classified request as it waits in the queue.
    // For K_QUAD, data[31:0] holds the quadrant values: upper left, upper right,
    // lower left, lower right, from the low byte up.
    typedef struct packed {
        t_kind                     kind;
        logic [63:0]               data;
        logic signed [BASE_W-1:0]  base;
        logic signed [GRAD_W-1:0]  grad_b;
        logic signed [GRAD_W-1:0]  grad_c;
    } t_desc;

endpackage

// ===== rtl/core/chroma_intra_predictor_8x8.sv =====
// Top level of the 8x8 chroma intra predictor.
// Depends on cip_pkg, cip_front, cip_queue, cip_back and the assertion header.
//
// Usage:
//   Request channel (i_valid / o_ready): one 8x8 chroma block with its mode,
//   the eight samples above, the eight to the left and the top-left corner.
//   Row channel (o_valid / i_ready): eight rows per request, top row first,
//   each with its row index and a last-row flag on row 7.
//   Row 0 passes through the queue, the back end's descriptor register and
//   its output register. Rows leave at one row per cycle while the receiver
//   is ready; the back end pulls the next request as its last row moves out.
//   The request queue holds QUEUE_DEPTH classified requests, so the front
//   keeps taking requests while the back end is still busy on earlier ones.
//   Reset empties the queue and drops any rows in flight.
//   When the receiver stalls, the current row holds; once the queue fills,
//   o_ready drops until rows drain.
module chroma_intra_predictor_8x8
    import cip_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [63:0] i_top_row,
    input  logic [63:0] i_left_col,
    input  logic [7:0]  i_corner,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_row_index,
    output logic [63:0] o_row_pixels,
    output logic        o_last_row
);

    t_desc front_desc;
    t_desc queue_desc;
    logic  queue_valid;
    logic  queue_pop;
    logic  back_busy;

    // Classify each request.
    cip_front u_front (
        .i_req_type (i_req_type),
        .i_top_row  (i_top_row),
        .i_left_col (i_left_col),
        .i_corner   (i_corner),
        .o_desc     (front_desc)
    );

    // Decouple the front from the back.
    cip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_valid),
        .i_push_desc  (front_desc),
        .o_push_ready (o_ready),
        .i_pop        (queue_pop),
        .o_pop_valid  (queue_valid),
        .o_pop_desc   (queue_desc)
    );

    // Produce the rows.
    cip_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (queue_valid),
        .i_desc       (queue_desc),
        .o_desc_pop   (queue_pop),
        .o_busy       (back_busy),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_row_index  (o_row_index),
        .o_row_pixels (o_row_pixels),
        .o_last_row   (o_last_row)
    );

`include "chroma_intra_predictor_8x8_assert.svh"

    // A taken row that is not the last is followed at once by the next row.
    `CIP_ASSERT_NEXT(a_row_follows, i_clk, i_rst_n, o_valid && i_ready && !o_last_row, o_valid && (o_row_index == $past(o_row_index) + 3'd1))

    // The last-row flag marks row 7 and only row 7.
    `CIP_ASSERT_NOW(a_last_flag, i_clk, i_rst_n, o_valid, o_last_row == (o_row_index == 3'd7))

    // The back end only pulls a request from the queue when one is waiting.
    `CIP_ASSERT_NOW(a_pop_valid, i_clk, i_rst_n, queue_pop, queue_valid && (!back_busy || o_valid))

endmodule

// ===== rtl/core/cip_front.sv =====
// Front end: classifies a request and works out its DC and plane terms.
// Depends on cip_pkg.
module cip_front
    import cip_pkg::*;
(
    input  logic [2:0]  i_req_type,
    input  logic [63:0] i_top_row,
    input  logic [63:0] i_left_col,
    input  logic [7:0]  i_corner,
    output t_desc       o_desc
);

    localparam logic [2:0] MODE_DC    = 3'd0;
    localparam logic [2:0] MODE_HOR   = 3'd1;
    localparam logic [2:0] MODE_VER   = 3'd2;
    localparam logic [2:0] MODE_PLANE = 3'd3;
    localparam logic [2:0] MODE_DCL   = 3'd4;
    localparam logic [2:0] MODE_DCT   = 3'd5;
    localparam logic [7:0] FLAT       = 8'd128;

    logic [7:0]  top [8];
    logic [7:0]  lft [8];
    logic [9:0]  t0, t1, l0, l1;
    logic [10:0] sum_tl0, sum_tl1;
    logic [10:0] t0_r, t1_r, l0_r, l1_r;
    logic [7:0]  dc_all_ul, dc_all_lr, dc_t0, dc_t1, dc_l0, dc_l1;
    logic signed [12:0] hsum, vsum;
    logic signed [17:0] h17, v17;
    logic signed [BASE_W-1:0] b_ext, c_ext, a_ext;

    // Split the neighbor words into samples.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            top[k] = i_top_row[8*k +: 8];
            lft[k] = i_left_col[8*k +: 8];
        end
    end

    // Half sums of the neighbors and the rounded DC values.
    always_comb begin
        t0 = 10'(top[0]) + 10'(top[1]) + 10'(top[2]) + 10'(top[3]);
        t1 = 10'(top[4]) + 10'(top[5]) + 10'(top[6]) + 10'(top[7]);
        l0 = 10'(lft[0]) + 10'(lft[1]) + 10'(lft[2]) + 10'(lft[3]);
        l1 = 10'(lft[4]) + 10'(lft[5]) + 10'(lft[6]) + 10'(lft[7]);
        sum_tl0 = 11'(t0) + 11'(l0) + 11'd4;
        sum_tl1 = 11'(t1) + 11'(l1) + 11'd4;
        t0_r = 11'(t0) + 11'd2;
        t1_r = 11'(t1) + 11'd2;
        l0_r = 11'(l0) + 11'd2;
        l1_r = 11'(l1) + 11'd2;
        dc_all_ul = sum_tl0[10:3];
        dc_all_lr = sum_tl1[10:3];
        dc_t0 = t0_r[9:2];
        dc_t1 = t1_r[9:2];
        dc_l0 = l0_r[9:2];
        dc_l1 = l1_r[9:2];
    end

    // Plane gradients: weighted differences across the top and left edges.
    always_comb begin
        hsum = 13'sd1 * (13'(signed'({1'b0, top[4]})) - 13'(signed'({1'b0, top[2]})))
             + 13'sd2 * (13'(signed'({1'b0, top[5]})) - 13'(signed'({1'b0, top[1]})))
             + 13'sd3 * (13'(signed'({1'b0, top[6]})) - 13'(signed'({1'b0, top[0]})))
             + 13'sd4 * (13'(signed'({1'b0, top[7]})) - 13'(signed'({1'b0, i_corner})));
        vsum = 13'sd1 * (13'(signed'({1'b0, lft[4]})) - 13'(signed'({1'b0, lft[2]})))
             + 13'sd2 * (13'(signed'({1'b0, lft[5]})) - 13'(signed'({1'b0, lft[1]})))
             + 13'sd3 * (13'(signed'({1'b0, lft[6]})) - 13'(signed'({1'b0, lft[0]})))
             + 13'sd4 * (13'(signed'({1'b0, lft[7]})) - 13'(signed'({1'b0, i_corner})));
        // 17 * sum + 16, then floor division by 32.
        h17 = (18'(hsum) <<< 4) + 18'(hsum) + 18'sd16;
        v17 = (18'(vsum) <<< 4) + 18'(vsum) + 18'sd16;
        b_ext = BASE_W'(h17 >>> 5);
        c_ext = BASE_W'(v17 >>> 5);
        a_ext = BASE_W'(signed'({1'b0, (9'(lft[7]) + 9'(top[7])), 4'd0}));
    end

    // Build the descriptor for the back end.
    always_comb begin
        o_desc.grad_b = GRAD_W'(b_ext);
        o_desc.grad_c = GRAD_W'(c_ext);
        // Value at column 0, row 0, including the rounding term.
        o_desc.base   = a_ext + BASE_W'(16) - (b_ext + (b_ext <<< 1))
                        - (c_ext + (c_ext <<< 1));
        o_desc.kind   = K_QUAD;
        o_desc.data   = '0;
        unique case (i_req_type)
            MODE_DC: begin
                o_desc.data[31:0] = {dc_all_lr, dc_l1, dc_t1, dc_all_ul};
            end
            MODE_HOR: begin
                o_desc.kind = K_HOR;
                o_desc.data = i_left_col;
            end
            MODE_VER: begin
                o_desc.kind = K_VER;
                o_desc.data = i_top_row;
            end
            MODE_PLANE: begin
                o_desc.kind = K_PLANE;
            end
            MODE_DCL: begin
                o_desc.data[31:0] = {dc_l1, dc_l1, dc_l0, dc_l0};
            end
            MODE_DCT: begin
                o_desc.data[31:0] = {dc_t1, dc_t0, dc_t1, dc_t0};
            end
            default: begin
                o_desc.data[31:0] = {FLAT, FLAT, FLAT, FLAT};
            end
        endcase
    end

endmodule

// ===== rtl/core/cip_queue.sv =====
// Small request queue between the front and back ends.
// Depends on cip_pkg for the descriptor type.
module cip_queue
    import cip_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_push_desc,
    output logic  o_push_ready,
    input  logic  i_pop,
    output logic  o_pop_valid,
    output t_desc o_pop_desc
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_desc          r_mem [DEPTH];
    logic [PW-1:0]  r_wptr, r_rptr;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_desc   = r_mem[r_rptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    // Storage; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_desc;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/core/cip_back.sv =====
// Back end: walks one request through its eight rows into the output register.
// Depends on cip_pkg.
module cip_back
    import cip_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_desc_valid,
    input  t_desc       i_desc,
    output logic        o_desc_pop,
    output logic        o_busy,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_row_index,
    output logic [63:0] o_row_pixels,
    output logic        o_last_row
);

    t_desc                    r_desc;
    logic                     r_busy;
    logic [2:0]               r_row;
    logic signed [BASE_W-1:0] r_base;
    logic                     r_out_valid;
    logic [2:0]               r_out_index;
    logic [63:0]              r_out_pixels;
    logic                     r_out_last;

    logic                     adv;
    logic                     emit;
    logic                     row_last;
    logic [63:0]              n_pixels;
    logic [7:0]               q_lo, q_hi;
    logic signed [BASE_W-1:0] b_ext, c_ext, acc;
    logic signed [BASE_W-6:0] shr;

    assign adv        = !r_out_valid || i_ready;
    assign emit       = r_busy && adv;
    assign row_last   = (r_row == 3'd7);
    assign o_desc_pop = i_desc_valid && (!r_busy || (adv && row_last));
    assign o_busy     = r_busy;
    assign b_ext      = BASE_W'(r_desc.grad_b);
    assign c_ext      = BASE_W'(r_desc.grad_c);

    // Row builder for the current row.
    always_comb begin
        q_lo     = r_row[2] ? r_desc.data[23:16] : r_desc.data[7:0];
        q_hi     = r_row[2] ? r_desc.data[31:24] : r_desc.data[15:8];
        n_pixels = '0;
        acc      = r_base;
        shr      = '0;
        unique case (r_desc.kind)
            K_QUAD: begin
                n_pixels = {{4{q_hi}}, {4{q_lo}}};
            end
            K_HOR: begin
                n_pixels = {8{r_desc.data[8*r_row +: 8]}};
            end
            K_VER: begin
                n_pixels = r_desc.data;
            end
            K_PLANE: begin
                // Each column adds its own multiple of the horizontal gradient
                // to the row value, so the columns are built side by side.
                for (int x = 0; x < 8; x++) begin
                    acc = r_base + BASE_W'(x) * b_ext;
                    shr = (BASE_W-5)'(acc >>> 5);
                    if (shr < 0) begin
                        n_pixels[8*x +: 8] = 8'd0;
                    end else if (shr > 255) begin
                        n_pixels[8*x +: 8] = 8'd255;
                    end else begin
                        n_pixels[8*x +: 8] = shr[7:0];
                    end
                end
            end
            default: begin
                n_pixels = '0;
            end
        endcase
    end

    // Descriptor and row sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
        end else if (o_desc_pop) begin
            r_busy <= 1'b1;
            r_row  <= '0;
        end else if (emit) begin
            r_row <= r_row + 3'd1;
            if (row_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Descriptor payload and the running plane row value.
    always_ff @(posedge i_clk) begin
        if (o_desc_pop) begin
            r_desc <= i_desc;
            r_base <= i_desc.base;
        end else if (emit) begin
            r_base <= r_base + c_ext;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_busy;
        end
    end

    // Output row payload, loaded whenever a row moves out.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_index  <= r_row;
            r_out_pixels <= n_pixels;
            r_out_last   <= row_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_row_index  = r_out_index;
    assign o_row_pixels = r_out_pixels;
    assign o_last_row   = r_out_last;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the 8x8 chroma intra predictor.
// Depends only on the chroma_intra_predictor_8x8 RTL; predicts every row locally.

module tb_top;

    // Prediction mode codes carried in the request.
    localparam logic [2:0] MODE_DC      = 3'd0;
    localparam logic [2:0] MODE_HOR     = 3'd1;
    localparam logic [2:0] MODE_VER     = 3'd2;
    localparam logic [2:0] MODE_PLANE   = 3'd3;
    localparam logic [2:0] MODE_DC_LEFT = 3'd4;
    localparam logic [2:0] MODE_DC_TOP  = 3'd5;
    localparam logic [2:0] MODE_FLAT_A  = 3'd6;
    localparam logic [2:0] MODE_FLAT_B  = 3'd7;

    localparam logic [7:0] FLAT_SAMPLE    = 8'h80;
    localparam int         PIX_MAX        = 255;
    localparam int         ROWS_PER_BLOCK = 8;
    localparam int         RX_HOLD_CYCLES = 80;
    localparam int         STALL_LIMIT    = 1000;
    localparam int         DRAIN_CYCLES   = 16;
    localparam int         MAX_REPORTS    = 10;

    // One block request as the sender holds it.
    typedef struct {
        logic [2:0]  mode;
        logic [63:0] top_row;
        logic [63:0] left_col;
        logic [7:0]  corner;
        bit          drain_first;
    } chroma_req_t;

    // One predicted row as the receiver should see it.
    typedef struct packed {
        logic [2:0]  idx;
        logic [63:0] pixels;
        logic        last;
    } pred_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_req_type = '0;
    logic [63:0] i_top_row = '0;
    logic [63:0] i_left_col = '0;
    logic [7:0]  i_corner = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_row_index;
    logic [63:0] o_row_pixels;
    logic        o_last_row;

    chroma_req_t pending_blocks[$];
    pred_row_t   rows_due[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_tickets = 0;
    int mismatches = 0;
    int blocks_sent = 0;
    int rows_checked = 0;
    int mode_hits[8];

    chroma_intra_predictor_8x8 i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_top_row    (i_top_row),
        .i_left_col   (i_left_col),
        .i_corner     (i_corner),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_row_index  (o_row_index),
        .o_row_pixels (o_row_pixels),
        .o_last_row   (o_last_row)
    );

    always #5 i_clk = ~i_clk;

    // Replicate one value into the low four samples and another into the high four.
    function automatic logic [63:0] split_fill(input int unsigned lo, input int unsigned hi);
        logic [7:0] lo_b;
        logic [7:0] hi_b;
        lo_b = lo[7:0];
        hi_b = hi[7:0];
        return {{4{hi_b}}, {4{lo_b}}};
    endfunction

    // Compute the eight rows of one request and queue them for the row checker.
    function automatic void predict_block_rows(input chroma_req_t r);
        int unsigned t0, t1, l0, l1;
        int          hsum, vsum, up_lo, lf_lo, a, b, c, v;
        logic [63:0] pix;
        pred_row_t   row;
        t0 = 0; t1 = 0; l0 = 0; l1 = 0;
        hsum = 0; vsum = 0;
        for (int i = 0; i < 4; i++) begin
            t0 += 32'(r.top_row[8*i +: 8]);
            t1 += 32'(r.top_row[8*(i+4) +: 8]);
            l0 += 32'(r.left_col[8*i +: 8]);
            l1 += 32'(r.left_col[8*(i+4) +: 8]);
        end
        // Plane gradients: the outermost pair uses the corner in place of sample -1.
        for (int i = 0; i < 4; i++) begin
            up_lo = (i == 3) ? int'(r.corner) : int'(r.top_row[8*(2-i) +: 8]);
            lf_lo = (i == 3) ? int'(r.corner) : int'(r.left_col[8*(2-i) +: 8]);
            hsum += (i + 1) * (int'(r.top_row[8*(4+i) +: 8]) - up_lo);
            vsum += (i + 1) * (int'(r.left_col[8*(4+i) +: 8]) - lf_lo);
        end
        a = (int'(r.left_col[63:56]) + int'(r.top_row[63:56])) * 16;
        b = (17 * hsum + 16) >>> 5;
        c = (17 * vsum + 16) >>> 5;
        for (int y = 0; y < ROWS_PER_BLOCK; y++) begin
            case (r.mode)
                MODE_DC: begin
                    if (y < 4) pix = split_fill((t0 + l0 + 4) >> 3, (t1 + 2) >> 2);
                    else       pix = split_fill((l1 + 2) >> 2, (t1 + l1 + 4) >> 3);
                end
                MODE_HOR:     pix = {8{r.left_col[8*y +: 8]}};
                MODE_VER:     pix = r.top_row;
                MODE_PLANE: begin
                    for (int x = 0; x < 8; x++) begin
                        v = (a + b * (x - 3) + c * (y - 3) + 16) >>> 5;
                        if (v < 0) v = 0;
                        if (v > PIX_MAX) v = PIX_MAX;
                        pix[8*x +: 8] = v[7:0];
                    end
                end
                MODE_DC_LEFT: begin
                    if (y < 4) pix = split_fill((l0 + 2) >> 2, (l0 + 2) >> 2);
                    else       pix = split_fill((l1 + 2) >> 2, (l1 + 2) >> 2);
                end
                MODE_DC_TOP:  pix = split_fill((t0 + 2) >> 2, (t1 + 2) >> 2);
                default:      pix = {8{FLAT_SAMPLE}};
            endcase
            row.idx    = y[2:0];
            row.pixels = pix;
            row.last   = (y == ROWS_PER_BLOCK - 1);
            rows_due.push_back(row);
        end
    endfunction

    // Count a failure and show the first few in detail.
    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Random sample word, biased toward the extremes so plane mode saturates often.
    function automatic logic [63:0] random_samples();
        logic [63:0] w;
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(7, 0))
                0:       w[8*i +: 8] = 8'h00;
                1:       w[8*i +: 8] = 8'hFF;
                default: w[8*i +: 8] = 8'($urandom_range(255, 0));
            endcase
        end
        return w;
    endfunction

    task automatic add_block(input logic [2:0] mode, input logic [63:0] top,
                             input logic [63:0] left, input logic [7:0] corner,
                             input bit drain_first);
        chroma_req_t r;
        r.mode        = mode;
        r.top_row     = top;
        r.left_col    = left;
        r.corner      = corner;
        r.drain_first = drain_first;
        pending_blocks.push_back(r);
    endtask

    // Random request with plane mode weighted up; every so often the sender drains first.
    task automatic add_random_blocks(input int count);
        logic [2:0] mode;
        int         pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(9, 0);
            mode = (pick > 7) ? MODE_PLANE : pick[2:0];
            add_block(mode, random_samples(), random_samples(), 8'($urandom_range(255, 0)),
                      (n % 40) == 39);
        end
    endtask

    task automatic wait_until_quiet();
        while (pending_blocks.size() != 0 || i_valid || rows_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Request driver: raises valid when the slot is free and holds the payload until taken.
    always @(posedge i_clk) begin : request_driver
        chroma_req_t taken;
        chroma_req_t nxt;
        bit          go;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                taken.mode     = i_req_type;
                taken.top_row  = i_top_row;
                taken.left_col = i_left_col;
                taken.corner   = i_corner;
                predict_block_rows(taken);
                mode_hits[i_req_type]++;
                blocks_sent++;
            end
            if (!i_valid || o_ready) begin
                go = 1'b0;
                if (pending_blocks.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
                    if (!pending_blocks[0].drain_first || rows_due.size() == 0)
                        go = 1'b1;
                end
                i_valid <= go;
                if (go) begin
                    nxt = pending_blocks.pop_front();
                    i_req_type <= nxt.mode;
                    i_top_row  <= nxt.top_row;
                    i_left_col <= nxt.left_col;
                    i_corner   <= nxt.corner;
                end
            end
        end
    end

    // Row monitor: checks each accepted row and throttles ready, with an occasional long hold.
    always @(posedge i_clk) begin : row_monitor
        pred_row_t want;
        int        hold_left;
        int        holds_seen;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            hold_left  = 0;
            holds_seen = 0;
        end else begin
            if (o_valid && i_ready) begin
                rows_checked++;
                if (rows_due.size() == 0) begin
                    report_mismatch("unexpected row", '0, o_row_pixels);
                end else begin
                    want = rows_due.pop_front();
                    if (o_row_index !== want.idx)
                        report_mismatch("row_index", 64'(want.idx), 64'(o_row_index));
                    if (o_row_pixels !== want.pixels)
                        report_mismatch("row_pixels", want.pixels, o_row_pixels);
                    if (o_last_row !== want.last)
                        report_mismatch("last_row", 64'(want.last), 64'(o_last_row));
                end
            end
            if (hold_left == 0 && holds_seen != rx_hold_tickets) begin
                holds_seen++;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: stop if work is outstanding and neither channel moves for too long.
    always @(posedge i_clk) begin : stall_watchdog
        int quiet_cycles;
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else if (pending_blocks.size() != 0 || i_valid || rows_due.size() != 0) begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: sender idles a little, receiver a lot.
        @(posedge i_clk);
        tx_idle_pct <= 15;
        rx_idle_pct <= 72;

        // Directed: every mode with all-zero and all-max neighbours.
        for (int m = 0; m < 8; m++) add_block(m[2:0], '0, '0, 8'h00, 1'b0);
        for (int m = 0; m < 8; m++) add_block(m[2:0], '1, '1, 8'hFF, 1'b0);
        // Plane with the steepest rising and falling gradients, saturating both ways.
        add_block(MODE_PLANE, 64'hFFFFFFFF_00000000, 64'hFFFFFFFF_00000000, 8'h00, 1'b0);
        add_block(MODE_PLANE, 64'h00000000_FFFFFFFF, 64'h00000000_FFFFFFFF, 8'hFF, 1'b0);
        add_block(MODE_PLANE, 64'hFF000000_00000000, 64'h00000000_000000FF, 8'hFF, 1'b0);
        // Corner-only gradient and a plain ramp.
        add_block(MODE_PLANE, 64'h80808080_80808080, 64'h80808080_80808080, 8'h00, 1'b0);
        add_block(MODE_PLANE, 64'hE0C0A080_60402000, 64'h1C18140F_0C080400, 8'h10, 1'b0);
        // DC with three different quadrant values, and row order in horizontal mode.
        add_block(MODE_DC, 64'hFFFFFFFF_00000000, 64'h00000000_FFFFFFFF, 8'h5A, 1'b0);
        add_block(MODE_HOR, 64'h0, 64'h0706050403020100, 8'hA5, 1'b0);
        add_block(MODE_DC_TOP, 64'h01010101_FEFEFEFE, 64'hFFFFFFFF_FFFFFFFF, 8'h00, 1'b1);
        add_random_blocks(100);
        wait_until_quiet();

        // Phase two: roles swapped.
        @(posedge i_clk);
        tx_idle_pct <= 72;
        rx_idle_pct <= 15;
        add_random_blocks(110);
        wait_until_quiet();

        // Phase three: no idling, but the receiver holds off long enough to fill the queue.
        @(posedge i_clk);
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        rx_hold_tickets <= rx_hold_tickets + 1;
        add_random_blocks(120);
        wait_until_quiet();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d block requests (DC %0d, plane %0d, flat %0d) and checked %0d rows,",
                 blocks_sent, mode_hits[MODE_DC], mode_hits[MODE_PLANE],
                 mode_hits[MODE_FLAT_A] + mode_hits[MODE_FLAT_B], rows_checked);
        $display("under three idle profiles with drain pauses and a long receiver hold.");
        if (mismatches == 0 && rows_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d rows still expected", mismatches, rows_due.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
